FILE: rtl/keepalive_conn_cache_lru_core_macros.svh
// assertion macros for the keep-alive connection cache
// both macros sample on clk_i and are switched off while rst_ni is low
`ifndef KEEPALIVE_CONN_CACHE_LRU_CORE_MACROS_SVH
`define KEEPALIVE_CONN_CACHE_LRU_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KCC_ASSERT_IMP(lbl, ante, cons, msg)
`define KCC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/kcc_pkg.sv
`default_nettype none

package kcc_pkg;

  localparam int SLOTS       = 16;
  localparam int HANDLE_BITS = 16;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_CACHED = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // one list update per cycle, issued by the sequencer
  typedef struct packed {
    logic  rm_en;      // remove recency entry at rm_pos, tail closes up
    slot_t rm_pos;
    logic  ins_en;     // insert slot at the most recent end
    slot_t ins_slot;
    logic  ins_keep;   // insert drops the tail, count unchanged (eviction)
    logic  push_en;    // push slot on the free stack
    slot_t push_slot;
    logic  pop_en;     // pop the free stack top
  } kcc_list_cmd_t;

  typedef struct packed {
    cnt_t             cached_cnt;
    cnt_t             free_cnt;
    slot_t            free_top;
    slot_t            rd_slot;
    logic [SLOTS-1:0] cached;
  } kcc_list_sts_t;

endpackage

`default_nettype wire

FILE: rtl/kcc_if.sv
`default_nettype none

interface kcc_in_if import kcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    peer_key;
  logic [HANDLE_W-1:0] conn_handle;
  logic [IDX_W-1:0]    slot_index;

  modport source (output valid, op, peer_key, conn_handle, slot_index, input ready);
  modport sink   (input valid, op, peer_key, conn_handle, slot_index, output ready);
endinterface

interface kcc_out_if import kcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] found_handle;
  logic [IDX_W-1:0]    slot_used;
  logic                evicted;
  logic [HANDLE_W-1:0] evicted_handle;

  modport source (output valid, status, found_handle, slot_used, evicted, evicted_handle,
                  input ready);
  modport sink   (input valid, status, found_handle, slot_used, evicted, evicted_handle,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/keepalive_conn_cache_lru_core.sv
// keep-alive connection cache, fully associative with least-recently-used replacement
//
// in_i carries one command beat: op (lookup, store, release), peer_key, conn_handle and
// slot_index; res_o returns exactly one result beat for every command beat.
// in_i.ready is high only while the sequencer is idle, so one command is worked on at a
// time. a lookup walks the recency list from the most recent end through one 64-bit key
// comparator fed by a registered key ram read. a store takes a free slot or, when none
// is free, evicts (extra handle ram read); a release is refused when its slot is not
// cached and else searches the recency list for its slot. the result register parts
// the two sides: a command may be accepted while the previous result still waits, and
// the sequencer only holds at its final step while res_o stalls. reset empties the
// recency list and stacks all slots as free, slot SLOTS-1 on top; the key and handle
// rams are not cleared, so the block is ready straight after reset.
`default_nettype none

`include "keepalive_conn_cache_lru_core_macros.svh"

module keepalive_conn_cache_lru_core import kcc_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  kcc_in_if.sink    in_i,
  kcc_out_if.source res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,     // lookup key walk
    S_RSCAN,    // release position search
    S_EVRD,     // read handle of the least recent slot
    S_EVWR      // overwrite the evicted slot
  } state_e;

  state_e               state_q, state_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [STORE_W-1:0]   hdl_q, hdl_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  cnt_t                 ptr_q, ptr_d;
  logic                 cmp_vld_q, cmp_vld_d;
  slot_t                cmp_pos_q, cmp_pos_d;
  slot_t                cmp_slot_q, cmp_slot_d;
  slot_t                ev_slot_q, ev_slot_d;

  logic                 out_vld_q, out_vld_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [HANDLE_W-1:0]  found_q, found_d;
  logic [IDX_W-1:0]     used_q, used_d;
  logic                 ev_q, ev_d;
  logic [HANDLE_W-1:0]  evh_q, evh_d;

  kcc_list_cmd_t        cmd;
  kcc_list_sts_t        sts;
  slot_t                rd_pos;

  logic                 ram_we, ram_re;
  slot_t                ram_waddr, ram_raddr;
  logic [KEY_W-1:0]     key_rd;
  logic [STORE_W-1:0]   conn_rd;

  logic                 out_free;
  logic                 key_hit;
  logic                 idx_ok;
  slot_t                idx_slot;
  cnt_t                 last_cnt;

  // list unit and slot payload stores
  kcc_lists u_lists (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .rd_pos_i (rd_pos),
    .sts_o    (sts)
  );

  kcc_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (key_rd)
  );

  kcc_ram #(.WIDTH(STORE_W), .DEPTH(SLOTS)) u_conn_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (hdl_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (conn_rd)
  );

  // a result may be written when the output register is empty or drains this cycle
  assign out_free = !out_vld_q || res_o.ready;
  // the single comparator: key read last cycle against the command key
  assign key_hit  = cmp_vld_q && (key_rd == key_q);
  assign idx_ok   = (32'(idx_q) < SLOTS);
  assign idx_slot = slot_t'(idx_q);
  assign last_cnt = sts.cached_cnt - cnt_t'(1);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    hdl_d      = hdl_q;
    idx_d      = idx_q;
    ptr_d      = ptr_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_pos_d  = cmp_pos_q;
    cmp_slot_d = cmp_slot_q;
    ev_slot_d  = ev_slot_q;

    out_vld_d  = out_vld_q && !res_o.ready;
    status_d   = status_q;
    found_d    = found_q;
    used_d     = used_q;
    ev_d       = ev_q;
    evh_d      = evh_q;

    cmd        = '0;
    rd_pos     = ptr_q[SLOT_W-1:0];
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = '0;
    ram_raddr  = sts.rd_slot;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.op;
          key_d   = in_i.peer_key;
          hdl_d   = in_i.conn_handle[STORE_W-1:0];
          idx_d   = in_i.slot_index;
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (op_q)
          OP_LOOKUP: begin
            ptr_d     = '0;
            cmp_vld_d = 1'b0;
            state_d   = S_SCAN;
          end
          OP_STORE: begin
            if (sts.free_cnt != '0) begin
              if (out_free) begin
                cmd.pop_en   = 1'b1;
                cmd.ins_en   = 1'b1;
                cmd.ins_slot = sts.free_top;
                ram_we       = 1'b1;
                ram_waddr    = sts.free_top;
                out_vld_d    = 1'b1;
                status_d     = ST_OK;
                found_d      = '0;
                used_d       = IDX_W'(sts.free_top);
                ev_d         = 1'b0;
                evh_d        = '0;
                state_d      = S_IDLE;
              end
            end else begin
              state_d = S_EVRD;
            end
          end
          OP_RELEASE: begin
            if (idx_ok && sts.cached[idx_slot]) begin
              ptr_d   = '0;
              state_d = S_RSCAN;
            end else if (out_free) begin
              out_vld_d = 1'b1;
              status_d  = ST_NOT_CACHED;
              found_d   = '0;
              used_d    = '0;
              ev_d      = 1'b0;
              evh_d     = '0;
              state_d   = S_IDLE;
            end
          end
          default: begin
            // unused op code, empty result
            if (out_free) begin
              out_vld_d = 1'b1;
              status_d  = ST_OK;
              found_d   = '0;
              used_d    = '0;
              ev_d      = 1'b0;
              evh_d     = '0;
              state_d   = S_IDLE;
            end
          end
        endcase
      end

      S_SCAN: begin
        // one entry issued and one compared per cycle until a hit, which holds while res_o stalls
        priority if (key_hit) begin
          if (out_free) begin
            cmd.rm_en     = 1'b1;
            cmd.rm_pos    = cmp_pos_q;
            cmd.push_en   = 1'b1;
            cmd.push_slot = cmp_slot_q;
            out_vld_d     = 1'b1;
            status_d      = ST_OK;
            found_d       = HANDLE_W'(conn_rd);
            used_d        = IDX_W'(cmp_slot_q);
            ev_d          = 1'b0;
            evh_d         = '0;
            state_d       = S_IDLE;
          end
        end else if (ptr_q < sts.cached_cnt) begin
          ram_re     = 1'b1;
          cmp_vld_d  = 1'b1;
          cmp_pos_d  = ptr_q[SLOT_W-1:0];
          cmp_slot_d = sts.rd_slot;
          ptr_d      = ptr_q + cnt_t'(1);
        end else begin
          if (out_free) begin
            out_vld_d = 1'b1;
            status_d  = ST_MISS;
            found_d   = '0;
            used_d    = '0;
            ev_d      = 1'b0;
            evh_d     = '0;
            state_d   = S_IDLE;
          end
        end
      end

      S_RSCAN: begin
        if (sts.rd_slot == idx_slot) begin
          if (out_free) begin
            cmd.rm_en     = 1'b1;
            cmd.rm_pos    = ptr_q[SLOT_W-1:0];
            cmd.push_en   = 1'b1;
            cmd.push_slot = idx_slot;
            out_vld_d     = 1'b1;
            status_d      = ST_OK;
            found_d       = '0;
            used_d        = idx_q;
            ev_d          = 1'b0;
            evh_d         = '0;
            state_d       = S_IDLE;
          end
        end else begin
          ptr_d = ptr_q + cnt_t'(1);
        end
      end

      S_EVRD: begin
        rd_pos    = last_cnt[SLOT_W-1:0];
        ram_re    = 1'b1;
        ev_slot_d = sts.rd_slot;
        state_d   = S_EVWR;
      end

      S_EVWR: begin
        // tail drops out as the slot re-enters at the most recent end
        if (out_free) begin
          cmd.ins_en   = 1'b1;
          cmd.ins_keep = 1'b1;
          cmd.ins_slot = ev_slot_q;
          ram_we       = 1'b1;
          ram_waddr    = ev_slot_q;
          out_vld_d    = 1'b1;
          status_d     = ST_OK;
          found_d      = '0;
          used_d       = IDX_W'(ev_slot_q);
          ev_d         = 1'b1;
          evh_d        = HANDLE_W'(conn_rd);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= '0;
      key_q      <= '0;
      hdl_q      <= '0;
      idx_q      <= '0;
      ptr_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_pos_q  <= '0;
      cmp_slot_q <= '0;
      ev_slot_q  <= '0;
      out_vld_q  <= 1'b0;
      status_q   <= '0;
      found_q    <= '0;
      used_q     <= '0;
      ev_q       <= 1'b0;
      evh_q      <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      key_q      <= key_d;
      hdl_q      <= hdl_d;
      idx_q      <= idx_d;
      ptr_q      <= ptr_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_pos_q  <= cmp_pos_d;
      cmp_slot_q <= cmp_slot_d;
      ev_slot_q  <= ev_slot_d;
      out_vld_q  <= out_vld_d;
      status_q   <= status_d;
      found_q    <= found_d;
      used_q     <= used_d;
      ev_q       <= ev_d;
      evh_q      <= evh_d;
    end
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign res_o.valid          = out_vld_q;
  assign res_o.status         = status_q;
  assign res_o.found_handle   = found_q;
  assign res_o.slot_used      = used_q;
  assign res_o.evicted        = ev_q;
  assign res_o.evicted_handle = evh_q;

  // every slot is on exactly one of the two lists
  `KCC_ASSERT_IMP(a_slots_conserved, 1'b1,
                  (32'(sts.cached_cnt) + 32'(sts.free_cnt)) == SLOTS,
                  "cached and free counts do not add up to the slot count")
  // cached flags agree with the recency list length
  `KCC_ASSERT_IMP(a_flags_match_count, 1'b1,
                  $countones(sts.cached) == 32'(sts.cached_cnt),
                  "cached flags disagree with recency list length")
  // a cached slot is always found before the walk runs off the list
  `KCC_ASSERT_IMP(a_release_in_range, state_q == S_RSCAN,
                  ptr_q < sts.cached_cnt,
                  "release search ran past the recency list")
  // one command at a time
  `KCC_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready,
                  "command accepted while busy")

endmodule

`default_nettype wire

FILE: rtl/kcc_ram.sv
`default_nettype none

module kcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kcc_lists.sv
`default_nettype none

// recency list, free stack and cached flags
module kcc_lists import kcc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire kcc_list_cmd_t cmd_i,
  input  wire slot_t         rd_pos_i,
  output      kcc_list_sts_t sts_o
);

  slot_t            rec_q [SLOTS];
  slot_t            rec_d [SLOTS];
  slot_t            fs_q  [SLOTS];
  slot_t            fs_d  [SLOTS];
  cnt_t             cached_cnt_q, cached_cnt_d;
  cnt_t             free_cnt_q, free_cnt_d;
  logic [SLOTS-1:0] cached_q, cached_d;
  cnt_t             top_cnt;

  assign top_cnt = free_cnt_q - cnt_t'(1);

  always_comb begin
    rec_d        = rec_q;
    fs_d         = fs_q;
    cached_cnt_d = cached_cnt_q;
    free_cnt_d   = free_cnt_q;
    cached_d     = cached_q;

    // close the gap behind the removed entry
    if (cmd_i.rm_en) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (slot_t'(i) >= cmd_i.rm_pos) begin
          rec_d[i] = rec_q[i + 1];
        end
      end
      cached_cnt_d = cached_cnt_q - cnt_t'(1);
    end

    if (cmd_i.ins_en) begin
      rec_d[0] = cmd_i.ins_slot;
      for (int i = 1; i < SLOTS; i++) begin
        rec_d[i] = rec_q[i - 1];
      end
      if (!cmd_i.ins_keep) begin
        cached_cnt_d = cached_cnt_q + cnt_t'(1);
      end
      cached_d[cmd_i.ins_slot] = 1'b1;
    end

    if (cmd_i.pop_en) begin
      free_cnt_d = top_cnt;
    end

    if (cmd_i.push_en) begin
      fs_d[free_cnt_q[SLOT_W-1:0]] = cmd_i.push_slot;
      free_cnt_d                   = free_cnt_q + cnt_t'(1);
      cached_d[cmd_i.push_slot]    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        fs_q[i] <= slot_t'(i);
      end
      cached_cnt_q <= '0;
      free_cnt_q   <= cnt_t'(SLOTS);
      cached_q     <= '0;
    end else begin
      fs_q         <= fs_d;
      cached_cnt_q <= cached_cnt_d;
      free_cnt_q   <= free_cnt_d;
      cached_q     <= cached_d;
    end
  end

  assign sts_o.cached_cnt = cached_cnt_q;
  assign sts_o.free_cnt   = free_cnt_q;
  assign sts_o.free_top   = fs_q[top_cnt[SLOT_W-1:0]];
  assign sts_o.rd_slot    = rec_q[rd_pos_i];
  assign sts_o.cached     = cached_q;

endmodule

`default_nettype wire
